/* sv/fav_pkg.sv */
package fav_pkg;

	// default table depth
	localparam int DEF_ENTRIES = 16;

	// configuration reset values
	localparam logic [4:0]  MAX_ENTRIES_RST = 5'd16;
	localparam logic [15:0] MAX_IDLE_RST    = 16'd8;

	// configuration register indexes (paddr[2])
	localparam logic REG_MAX_ENTRIES = 1'b0;
	localparam logic REG_MAX_IDLE    = 1'b1;

	typedef enum logic [1:0] {
		ACT_FIND    = 2'd0,
		ACT_PUBLISH = 2'd1,
		ACT_TRIM    = 2'd2,
		ACT_CLEAR   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_HIT       = 3'd0,
		ST_MISS      = 3'd1,
		ST_INSERTED  = 3'd2,
		ST_EVICTED   = 3'd3,
		ST_TRIMMED   = 3'd4,
		ST_CLEARED   = 3'd5
	} status_t;

	// lookup key of one entry
	typedef struct packed {
		logic [47:0] buffer_id;
		logic [47:0] view_offset;
		logic [47:0] view_size;
		logic [3:0]  view_type;
		logic [7:0]  view_format;
	} view_key_t;

	typedef struct packed {
		action_t     action;
		logic [47:0] buffer_id;
		logic [47:0] view_offset;
		logic [47:0] view_size;
		logic [3:0]  view_type;
		logic [7:0]  view_format;
		logic [31:0] view_handle;
		logic [47:0] frame_number;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] result_handle;
		logic [4:0]  removed_count;
	} out_item_t;

	// write strobes into the entry store
	typedef struct packed {
		logic key_we;
		logic frame_we;
	} store_wr_t;

endpackage

/* sv/frame_aged_view_cache_core.sv */
// Fully associative view cache with frame-based least-recently-used replacement.
// Items enter on start while busy is low; item carries action, key, candidate
// handle and current frame. Each item yields one result, shown on result for
// exactly one cycle with done high; the receiver must take it then.
// Find, publish and trim walk the entry store one slot per cycle through a
// single read port and one shared 48-bit subtract/compare, so such an item
// keeps busy high through the scan, last and done states; done is the
// registered copy of the done state. Clear keeps busy high for one cycle
// and goes straight from idle to the done state.
// The configuration port (APB) holds max_entries at 0x0 and max_idle_frames
// at 0x4; write them only while the block is idle.
// Reset empties the table (valid bits and entry count cleared) and loads
// max_entries 16 and max_idle_frames 8; stored keys, handles and frames are
// not cleared and are only ever used for valid entries.
module frame_aged_view_cache_core import fav_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    item,
	output logic        done,
	output out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_LAST = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic [4:0]  max_entries_q;
	logic [15:0] max_idle_q;

	in_item_t   item_q;
	view_key_t  key_q;

	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   removed_q;

	logic [IDX_W-1:0] rd_idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [31:0]      hit_handle_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             old_q;
	logic [IDX_W-1:0] old_idx_q;
	logic [47:0]      old_frame_q;

	logic        done_q;
	out_item_t   result_q;

	view_key_t   rd_key;
	logic [31:0] rd_handle;
	logic [47:0] rd_frame;

	store_wr_t        st_wr;
	logic [IDX_W-1:0] wr_addr;

	logic        accept;
	logic        cfg_wr;
	logic        is_trim;
	logic        slot_valid;
	logic        key_match;
	logic [47:0] sub_a;
	logic [47:0] sub_b;
	logic [48:0] diff;
	logic        older;
	logic        stale;
	logic [LIM_W-1:0] lim_raw;
	logic [LIM_W-1:0] lim;
	logic        evict;
	logic [IDX_W-1:0] ins_idx;
	logic        is_lookup;
	logic        pub_miss;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
			max_idle_q    <= MAX_IDLE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MAX_ENTRIES: max_entries_q <= pwdata[4:0];
				REG_MAX_IDLE:    max_idle_q    <= pwdata[15:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAX_ENTRIES: prdata = 32'(max_entries_q);
			REG_MAX_IDLE:    prdata = 32'(max_idle_q);
			default:         prdata = '0;
		endcase
	end

	// entry store
	fav_store #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_store (
		.clk       (clk),
		.rd_addr   (rd_idx_q),
		.rd_key    (rd_key),
		.rd_handle (rd_handle),
		.rd_frame  (rd_frame),
		.wr        (st_wr),
		.wr_addr   (wr_addr),
		.wr_key    (key_q),
		.wr_handle (item_q.view_handle),
		.wr_frame  (item_q.frame_number)
	);

	// key of the held item
	assign key_q = '{buffer_id:   item_q.buffer_id,
	                 view_offset: item_q.view_offset,
	                 view_size:   item_q.view_size,
	                 view_type:   item_q.view_type,
	                 view_format: item_q.view_format};

	assign is_trim    = (item_q.action == ACT_TRIM);
	assign slot_valid = valid_q[idx_s1];
	assign key_match  = slot_valid && (rd_key == key_q);

	// shared subtractor: age for trim, frame order for the oldest-entry search
	assign sub_a = is_trim ? item_q.frame_number : rd_frame;
	assign sub_b = is_trim ? rd_frame : old_frame_q;
	assign diff  = {1'b0, sub_a} - {1'b0, sub_b};
	assign older = diff[48];
	assign stale = slot_valid && !diff[48] && (diff[47:0] > 48'(max_idle_q));

	// effective entry limit, clamped to 1..ENTRIES
	assign lim_raw = LIM_W'(max_entries_q);
	always_comb begin
		if (lim_raw == '0) begin
			lim = LIM_W'(1);
		end else if (lim_raw > LIM_W'(ENTRIES)) begin
			lim = LIM_W'(ENTRIES);
		end else begin
			lim = lim_raw;
		end
	end

	assign evict = (LIM_W'(count_q) >= lim) && old_q;

	// insert into the lowest free slot once the victim is gone
	always_comb begin
		if (evict && (!free_q || (old_idx_q < free_idx_q))) begin
			ins_idx = old_idx_q;
		end else begin
			ins_idx = free_idx_q;
		end
	end

	assign is_lookup = (item_q.action == ACT_FIND) || (item_q.action == ACT_PUBLISH);
	assign pub_miss  = (item_q.action == ACT_PUBLISH) && !hit_q;

	// store writes happen in the final cycle
	always_comb begin
		st_wr   = '0;
		wr_addr = hit_idx_q;
		if (state_q == S_DONE && is_lookup) begin
			if (hit_q) begin
				st_wr.frame_we = 1'b1;
			end else if (pub_miss) begin
				st_wr.key_we   = 1'b1;
				st_wr.frame_we = 1'b1;
				wr_addr        = ins_idx;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_SCAN);
			unique case (state_q)
				S_IDLE: begin
					rd_idx_q <= '0;
					if (accept) begin
						state_q <= (item.action == ACT_CLEAR) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
					if (rd_idx_q == LAST_IDX) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (accept) begin
			item_q <= item;
		end
	end

	// scan trackers: first hit, first free slot, oldest valid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			old_q  <= 1'b0;
		end else if (accept) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			old_q  <= 1'b0;
		end else if (vld_s1 && !is_trim) begin
			if (key_match && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!slot_valid && !free_q) begin
				free_q <= 1'b1;
			end
			if (slot_valid) begin
				old_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && !is_trim) begin
			if (key_match && !hit_q) begin
				hit_idx_q    <= idx_s1;
				hit_handle_q <= rd_handle;
			end
			if (!slot_valid && !free_q) begin
				free_idx_q <= idx_s1;
			end
			if (slot_valid && (!old_q || older)) begin
				old_idx_q   <= idx_s1;
				old_frame_q <= rd_frame;
			end
		end
	end

	// valid bits, occupancy and removal count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			count_q   <= '0;
			removed_q <= '0;
		end else begin
			if (accept) begin
				removed_q <= '0;
			end
			if (vld_s1 && is_trim && stale) begin
				valid_q[idx_s1] <= 1'b0;
				count_q         <= count_q - CNT_W'(1);
				removed_q       <= removed_q + CNT_W'(1);
			end
			if (state_q == S_DONE) begin
				if (item_q.action == ACT_CLEAR) begin
					valid_q <= '0;
					count_q <= '0;
				end else if (pub_miss) begin
					if (evict) begin
						valid_q[old_idx_q] <= 1'b0;
					end else begin
						count_q <= count_q + CNT_W'(1);
					end
					valid_q[ins_idx] <= 1'b1;
				end
			end
		end
	end

	// result register, one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == S_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			result_q.result_handle <= '0;
			result_q.removed_count <= '0;
			case (item_q.action)
				ACT_FIND, ACT_PUBLISH: begin
					if (hit_q) begin
						result_q.status        <= ST_HIT;
						result_q.result_handle <= hit_handle_q;
					end else if (item_q.action == ACT_FIND) begin
						result_q.status <= ST_MISS;
					end else begin
						result_q.status        <= evict ? ST_EVICTED : ST_INSERTED;
						result_q.result_handle <= item_q.view_handle;
						result_q.removed_count <= evict ? 5'd1 : 5'd0;
					end
				end
				ACT_TRIM: begin
					result_q.status        <= ST_TRIMMED;
					result_q.removed_count <= 5'(removed_q);
				end
				default: begin
					result_q.status        <= ST_CLEARED;
					result_q.removed_count <= 5'(count_q);
				end
			endcase
		end
	end

endmodule

/* sv/fav_store.sv */
module fav_store import fav_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES,
	parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic             clk,
	input  logic [IDX_W-1:0] rd_addr,
	output view_key_t        rd_key,
	output logic [31:0]      rd_handle,
	output logic [47:0]      rd_frame,
	input  store_wr_t        wr,
	input  logic [IDX_W-1:0] wr_addr,
	input  view_key_t        wr_key,
	input  logic [31:0]      wr_handle,
	input  logic [47:0]      wr_frame
);

	view_key_t   key_mem [ENTRIES];
	logic [31:0] handle_mem [ENTRIES];
	logic [47:0] frame_mem [ENTRIES];

	// key and handle are written together on insert
	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_mem[wr_addr]    <= wr_key;
			handle_mem[wr_addr] <= wr_handle;
		end
		if (wr.frame_we) begin
			frame_mem[wr_addr] <= wr_frame;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_key    <= key_mem[rd_addr];
		rd_handle <= handle_mem[rd_addr];
		rd_frame  <= frame_mem[rd_addr];
	end

endmodule

/* verif/tb_frame_aged_view_cache_core.sv */
module tb_frame_aged_view_cache_core;
	import fav_pkg::*;

	localparam int ENTRIES   = DEF_ENTRIES;
	localparam int POOL_MAX  = 24;
	localparam int PHASES    = 9;
	localparam int PHASE_LEN = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	in_item_t    item = '0;
	logic        done;
	out_item_t   result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	frame_aged_view_cache_core #(.ENTRIES(ENTRIES)) dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .item(item),
		.done(done), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// shadow copy of the cache contents and registers
	logic        shadow_valid [ENTRIES];
	view_key_t   shadow_key [ENTRIES];
	logic [31:0] shadow_handle [ENTRIES];
	logic [47:0] shadow_frame [ENTRIES];
	int          shadow_count;
	logic [4:0]  shadow_max_entries;
	logic [15:0] shadow_max_idle;

	out_item_t results_due[$];
	int        fail_count = 0;
	int        burst_left = 0;

	view_key_t   key_pool [POOL_MAX];
	int          pool_size;
	logic [47:0] frame_now;

	// directed stimulus table
	typedef struct {
		bit          is_cfg;
		logic        cfg_reg;
		logic [31:0] cfg_val;
		in_item_t    req;
		bit          typed;
		out_item_t   want;
	} dir_row_t;

	dir_row_t dir_rows[$];

	// expected result of one item, advancing the shadow state
	function automatic out_item_t cache_predict(in_item_t it);
		out_item_t   r;
		view_key_t   k;
		int          slot;
		int          oldest;
		int          lim;
		int          i;
		r.status = ST_HIT;
		r.result_handle = '0;
		r.removed_count = '0;
		k.buffer_id = it.buffer_id;
		k.view_offset = it.view_offset;
		k.view_size = it.view_size;
		k.view_type = it.view_type;
		k.view_format = it.view_format;
		slot = -1;
		case (it.action)
		ACT_FIND, ACT_PUBLISH: begin
			for (i = 0; i < ENTRIES; i++)
				if (slot < 0 && shadow_valid[i] && shadow_key[i] == k)
					slot = i;
			if (slot >= 0) begin
				shadow_frame[slot] = it.frame_number;
				r.result_handle = shadow_handle[slot];
			end else if (it.action == ACT_FIND) begin
				r.status = ST_MISS;
			end else begin
				r.status = ST_INSERTED;
				lim = shadow_max_entries;
				if (lim < 1) lim = 1;
				if (lim > ENTRIES) lim = ENTRIES;
				// full table: drop the least recently used, lowest slot on a tie
				if (shadow_count >= lim) begin
					oldest = -1;
					for (i = 0; i < ENTRIES; i++)
						if (shadow_valid[i] &&
						    (oldest < 0 || shadow_frame[i] < shadow_frame[oldest]))
							oldest = i;
					if (oldest >= 0) begin
						shadow_valid[oldest] = 1'b0;
						shadow_count--;
						r.status = ST_EVICTED;
						r.removed_count = 5'd1;
					end
				end
				for (i = 0; i < ENTRIES; i++)
					if (slot < 0 && !shadow_valid[i])
						slot = i;
				if (slot >= 0) begin
					shadow_valid[slot] = 1'b1;
					shadow_key[slot] = k;
					shadow_handle[slot] = it.view_handle;
					shadow_frame[slot] = it.frame_number;
					shadow_count++;
				end
				r.result_handle = it.view_handle;
			end
		end
		ACT_TRIM: begin
			r.status = ST_TRIMMED;
			for (i = 0; i < ENTRIES; i++)
				if (shadow_valid[i] && it.frame_number > shadow_frame[i] &&
				    (it.frame_number - shadow_frame[i]) > {32'd0, shadow_max_idle}) begin
					shadow_valid[i] = 1'b0;
					shadow_count--;
					r.removed_count++;
				end
		end
		default: begin
			r.status = ST_CLEARED;
			r.removed_count = shadow_count[4:0];
			for (i = 0; i < ENTRIES; i++)
				shadow_valid[i] = 1'b0;
			shadow_count = 0;
		end
		endcase
		return r;
	endfunction

	function automatic in_item_t mk_item(action_t a, view_key_t k, logic [31:0] h,
	                                     logic [47:0] f);
		in_item_t it;
		it.action = a;
		it.buffer_id = k.buffer_id;
		it.view_offset = k.view_offset;
		it.view_size = k.view_size;
		it.view_type = k.view_type;
		it.view_format = k.view_format;
		it.view_handle = h;
		it.frame_number = f;
		return it;
	endfunction

	function automatic out_item_t mk_result(status_t s, logic [31:0] h, logic [4:0] n);
		out_item_t r;
		r.status = s;
		r.result_handle = h;
		r.removed_count = n;
		return r;
	endfunction

	function automatic logic [47:0] rand48();
		return {$urandom_range(0, 16'hFFFF), $urandom()};
	endfunction

	function automatic view_key_t rand_key();
		view_key_t k;
		k.buffer_id = rand48();
		k.view_offset = rand48();
		k.view_size = rand48();
		k.view_type = $urandom_range(0, 15);
		k.view_format = $urandom_range(0, 255);
		return k;
	endfunction

	// idle cycles before the next item, with bursts of back-to-back items
	function automatic int draw_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 7) == 0) begin
			burst_left = $urandom_range(5, 30);
			return 0;
		end
		return $urandom_range(0, 10);
	endfunction

	task automatic send_item(in_item_t it, bit typed, out_item_t want);
		int        gap;
		out_item_t pred;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pred = cache_predict(it);
		results_due.push_back(typed ? want : pred);
	endtask

	// stop issuing and wait until every result is back
	task automatic settle();
		start <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (ENTRIES + 4) @(posedge clk);
	endtask

	task automatic cfg_write(logic reg_idx, logic [31:0] val);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx == REG_MAX_ENTRIES)
			shadow_max_entries = val[4:0];
		else
			shadow_max_idle = val[15:0];
	endtask

	task automatic add_item(action_t a, view_key_t k, logic [31:0] h, logic [47:0] f,
	                        bit typed, out_item_t want);
		dir_row_t row;
		row.is_cfg = 1'b0;
		row.cfg_reg = REG_MAX_ENTRIES;
		row.cfg_val = '0;
		row.req = mk_item(a, k, h, f);
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	task automatic add_cfg(logic reg_idx, logic [31:0] val);
		dir_row_t row;
		row.is_cfg = 1'b1;
		row.cfg_reg = reg_idx;
		row.cfg_val = val;
		row.req = '0;
		row.typed = 1'b0;
		row.want = '0;
		dir_rows.push_back(row);
	endtask

	// random item, its key mostly drawn from the key pool, with a slowly advancing frame
	task automatic send_random();
		int          pick;
		action_t     a;
		view_key_t   k;
		logic [47:0] f;
		pick = $urandom_range(0, 99);
		if (pick < 40)      a = ACT_FIND;
		else if (pick < 85) a = ACT_PUBLISH;
		else if (pick < 96) a = ACT_TRIM;
		else                a = ACT_CLEAR;
		if ($urandom_range(0, 9) == 0)
			k = rand_key();
		else
			k = key_pool[$urandom_range(0, pool_size - 1)];
		frame_now += $urandom_range(0, 3);
		if ($urandom_range(0, 19) == 0)
			frame_now += $urandom_range(0, 2 * shadow_max_idle + 2);
		f = frame_now;
		if ($urandom_range(0, 14) == 0)
			f = frame_now - $urandom_range(0, 50);
		send_item(mk_item(a, k, $urandom(), f), 1'b0, '0);
	endtask

	// new key pool; some keys differ from the first in a single field
	task automatic new_pool();
		int i;
		pool_size = $urandom_range(4, POOL_MAX);
		for (i = 0; i < pool_size; i++) begin
			key_pool[i] = rand_key();
			if (i > 0 && $urandom_range(0, 1) == 1) begin
				key_pool[i] = key_pool[0];
				case ($urandom_range(0, 4))
				0: key_pool[i].buffer_id = rand48();
				1: key_pool[i].view_offset = rand48();
				2: key_pool[i].view_size = rand48();
				3: key_pool[i].view_type = key_pool[0].view_type ^ 4'(1 << $urandom_range(0, 3));
				default: key_pool[i].view_format = $urandom_range(0, 255);
				endcase
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		out_item_t want;
		if (done) begin
			if (results_due.size() == 0) begin
				$error("unexpected result: status %0d handle %0h removed %0d",
				       result.status, result.result_handle, result.removed_count);
				fail_count++;
			end else begin
				want = results_due.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					fail_count++;
				end
				if (result.result_handle !== want.result_handle) begin
					$error("result_handle: expected %0h, got %0h",
					       want.result_handle, result.result_handle);
					fail_count++;
				end
				if (result.removed_count !== want.removed_count) begin
					$error("removed_count: expected %0d, got %0d",
					       want.removed_count, result.removed_count);
					fail_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		#3000000;
		$display("FAIL frame_aged_view_cache_core");
		$finish;
	end

	// main sequence
	initial begin
		view_key_t   ka, kb, kc, kd, ke, kf, kg, kg_near;
		logic [4:0]  lim_list [PHASES];
		logic [15:0] idle_list [PHASES];
		int          i;
		int          p;

		for (i = 0; i < ENTRIES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_key[i] = '0;
			shadow_handle[i] = '0;
			shadow_frame[i] = '0;
		end
		shadow_count = 0;
		shadow_max_entries = MAX_ENTRIES_RST;
		shadow_max_idle = MAX_IDLE_RST;

		ka = '0;
		kb = '1;
		kc = kb;
		kc.view_format = 8'hFE;
		kd = '{48'h1, 48'h2, 48'h3, 4'h4, 8'h5};
		ke = '{48'h1, 48'h2, 48'h3, 4'h5, 8'h5};
		kf = '{48'hA0A0, 48'h0, 48'h100, 4'h1, 8'h21};
		kg = '{48'h123456789ABC, 48'h40, 48'h80, 4'h2, 8'h3};
		kg_near = kg;
		kg_near.buffer_id[47] = 1'b1;

		// empty table after reset
		add_item(ACT_FIND, ka, 32'd9, 48'd0, 1'b1, mk_result(ST_MISS, '0, '0));
		add_item(ACT_CLEAR, ka, 32'd0, 48'd0, 1'b1, mk_result(ST_CLEARED, '0, '0));
		add_item(ACT_TRIM, ka, 32'd0, '1, 1'b1, mk_result(ST_TRIMMED, '0, '0));
		// zero handle, all-zero and all-ones keys
		add_item(ACT_PUBLISH, ka, 32'd0, 48'd0, 1'b1, mk_result(ST_INSERTED, '0, '0));
		add_item(ACT_FIND, ka, 32'd1, 48'd5, 1'b1, mk_result(ST_HIT, '0, '0));
		add_item(ACT_PUBLISH, kb, '1, '1, 1'b1, mk_result(ST_INSERTED, '1, '0));
		add_item(ACT_PUBLISH, kb, 32'h1234, '1, 1'b1, mk_result(ST_HIT, '1, '0));
		add_item(ACT_PUBLISH, kc, 32'd7, 48'd10, 1'b0, '0);
		// trim with a frame older than every entry removes nothing
		add_item(ACT_TRIM, ka, 32'd0, 48'd3, 1'b1, mk_result(ST_TRIMMED, '0, '0));
		add_item(ACT_TRIM, ka, 32'd0, 48'd14, 1'b0, '0);
		// limit of zero acts as one, below occupancy
		add_cfg(REG_MAX_ENTRIES, 32'd0);
		add_item(ACT_PUBLISH, kd, 32'h55, 48'd20, 1'b0, '0);
		add_item(ACT_PUBLISH, ke, 32'h66, 48'd20, 1'b0, '0);
		// equal frames: lowest slot goes first
		add_cfg(REG_MAX_ENTRIES, 32'd2);
		add_item(ACT_FIND, kb, 32'd0, 48'd20, 1'b0, '0);
		add_item(ACT_PUBLISH, kf, 32'h77, 48'd21, 1'b0, '0);
		// limit above capacity, zero idle allowance
		add_cfg(REG_MAX_ENTRIES, 32'd31);
		add_cfg(REG_MAX_IDLE, 32'd0);
		add_item(ACT_TRIM, ka, 32'd0, 48'd22, 1'b0, '0);
		add_cfg(REG_MAX_IDLE, 32'hFFFF);
		add_item(ACT_PUBLISH, kg, 32'h8000_0001, 48'd30, 1'b0, '0);
		add_item(ACT_FIND, kg_near, 32'd0, 48'd31, 1'b0, '0);
		add_item(ACT_FIND, kg, 32'd0, 48'd31, 1'b0, '0);
		add_item(ACT_CLEAR, ka, 32'd0, 48'd32, 1'b0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].is_cfg)
				cfg_write(dir_rows[r].cfg_reg, dir_rows[r].cfg_val);
			else
				send_item(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].want);
		end

		// random phases over a spread of settings
		lim_list  = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd8, 5'd16, 5'd2, 5'd0};
		idle_list = '{16'd8, 16'd0, 16'd3, 16'hFFFF, 16'd20, 16'd2, 16'd100, 16'd1, 16'd0};
		lim_list[PHASES - 1] = $urandom_range(0, 31);
		idle_list[PHASES - 1] = $urandom_range(0, 40);
		for (p = 0; p < PHASES; p++) begin
			cfg_write(REG_MAX_ENTRIES, {27'd0, lim_list[p]});
			cfg_write(REG_MAX_IDLE, {16'd0, idle_list[p]});
			new_pool();
			frame_now = rand48();
			for (i = 0; i < PHASE_LEN; i++)
				send_random();
		end

		settle();
		if (fail_count == 0 && results_due.size() == 0)
			$display("PASS frame_aged_view_cache_core");
		else
			$display("FAIL frame_aged_view_cache_core");
		$finish;
	end

endmodule
